### rtl/sws_pkg.sv
// Shared types, codes and constants of the sliding-window sender.
// No dependencies; every other file of the block refers to this package.
package sws_pkg;

  localparam int unsigned BUFFER_DEPTH_DEF = 32;
  localparam int unsigned TIME_BITS_DEF    = 32;
  localparam int unsigned MAX_PAYLOAD      = 512;
  localparam int unsigned TIMEOUT_RST      = 1000;
  localparam int unsigned WINDOW_RST       = 1;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned SEQ_W   = 8;
  localparam int unsigned WIN_W   = 5;
  localparam int unsigned NOW_W   = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned OCC_W   = 6;
  localparam int unsigned CFG_W   = 32;

  localparam int unsigned IN_LEN_LSB  = 0;
  localparam int unsigned IN_ASEQ_LSB = IN_LEN_LSB + LEN_W;
  localparam int unsigned IN_AWIN_LSB = IN_ASEQ_LSB + SEQ_W;
  localparam int unsigned IN_NOW_LSB  = IN_AWIN_LSB + WIN_W;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQUEUE = 2'd0,
    FUNC_POLL    = 2'd1,
    FUNC_ACK     = 2'd2
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_SEND      = 3'd2,
    KIND_POLL_NONE = 3'd3,
    KIND_ACK_DONE  = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ENQ,
    S_SCAN_CHK,
    S_SCAN_EV,
    S_SEND_CHK,
    S_SEND_EV,
    S_POLL_NONE,
    S_ACK_CHK,
    S_ACK_EV,
    S_ACK_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic enq;
    logic scan_init;
    logic send_init;
    logic rd;
    logic scan_eval;
    logic idx_inc;
    logic send_eval;
    logic poll_none;
    logic ack_start;
    logic ack_pop;
    logic ack_emit;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  walk_more;
    logic  due_cur;
    logic  any_due;
    logic  ring_empty;
    logic  ack_hit;
    logic  out_free;
  } status_t;

endpackage

### rtl/sws_ctrl.sv
// Controller state machine of the sliding-window sender.
// Depends on sws_pkg; drives sws_datapath through cmd_t and reads status_t.
module sws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sws_pkg::status_t  status_i,
  output sws_pkg::cmd_t     cmd_o
);

  sws_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sws_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sws_pkg::S_IDLE: begin
        if (in_valid_i) state_d = sws_pkg::S_DECODE;
      end
      sws_pkg::S_DECODE: begin
        unique case (status_i.func)
          sws_pkg::FUNC_ENQUEUE: state_d = sws_pkg::S_ENQ;
          sws_pkg::FUNC_POLL:    state_d = sws_pkg::S_SCAN_CHK;
          sws_pkg::FUNC_ACK:     state_d = sws_pkg::S_ACK_CHK;
          default:               state_d = sws_pkg::S_IDLE;
        endcase
      end
      sws_pkg::S_ENQ: begin
        if (status_i.out_free) state_d = sws_pkg::S_IDLE;
      end
      sws_pkg::S_SCAN_CHK: begin
        if (status_i.walk_more) begin
          state_d = sws_pkg::S_SCAN_EV;
        end else if (status_i.any_due) begin
          state_d = sws_pkg::S_SEND_CHK;
        end else begin
          state_d = sws_pkg::S_POLL_NONE;
        end
      end
      sws_pkg::S_SCAN_EV: state_d = sws_pkg::S_SCAN_CHK;
      sws_pkg::S_SEND_CHK: begin
        if (!status_i.walk_more) begin
          state_d = sws_pkg::S_IDLE;
        end else if (status_i.due_cur) begin
          state_d = sws_pkg::S_SEND_EV;
        end
      end
      sws_pkg::S_SEND_EV: begin
        if (status_i.out_free) state_d = sws_pkg::S_SEND_CHK;
      end
      sws_pkg::S_POLL_NONE: begin
        if (status_i.out_free) state_d = sws_pkg::S_IDLE;
      end
      sws_pkg::S_ACK_CHK: begin
        if (status_i.ring_empty) begin
          state_d = sws_pkg::S_ACK_DONE;
        end else begin
          state_d = sws_pkg::S_ACK_EV;
        end
      end
      sws_pkg::S_ACK_EV: begin
        if (status_i.ack_hit) begin
          state_d = sws_pkg::S_ACK_DONE;
        end else begin
          state_d = sws_pkg::S_ACK_CHK;
        end
      end
      sws_pkg::S_ACK_DONE: begin
        if (status_i.out_free) state_d = sws_pkg::S_IDLE;
      end
      default: state_d = sws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      sws_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      sws_pkg::S_DECODE: begin
        cmd_o.scan_init = (status_i.func == sws_pkg::FUNC_POLL);
        cmd_o.ack_start = (status_i.func == sws_pkg::FUNC_ACK);
      end
      sws_pkg::S_ENQ: cmd_o.enq = status_i.out_free;
      sws_pkg::S_SCAN_CHK: begin
        cmd_o.rd        = status_i.walk_more;
        cmd_o.send_init = !status_i.walk_more && status_i.any_due;
      end
      sws_pkg::S_SCAN_EV: cmd_o.scan_eval = 1'b1;
      sws_pkg::S_SEND_CHK: begin
        cmd_o.rd      = status_i.walk_more && status_i.due_cur;
        cmd_o.idx_inc = status_i.walk_more && !status_i.due_cur;
      end
      sws_pkg::S_SEND_EV:   cmd_o.send_eval = status_i.out_free;
      sws_pkg::S_POLL_NONE: cmd_o.poll_none = status_i.out_free;
      sws_pkg::S_ACK_CHK:   cmd_o.rd        = !status_i.ring_empty;
      sws_pkg::S_ACK_EV:    cmd_o.ack_pop   = !status_i.ack_hit;
      sws_pkg::S_ACK_DONE:  cmd_o.ack_emit  = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

### rtl/sws_datapath.sv
// Datapath of the sliding-window sender: descriptor ring memories, ring
// pointers, window walk bookkeeping and the result register. Depends on sws_pkg.
module sws_datapath #(
  parameter int unsigned BUFFER_DEPTH = sws_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned TIME_BITS    = sws_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sws_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic [sws_pkg::IN_TDATA_W-1:0]    in_tdata_i,
  input  logic [sws_pkg::FUNC_W-1:0]        in_tuser_i,
  input  sws_pkg::cmd_t                     cmd_i,
  output sws_pkg::status_t                  status_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [sws_pkg::OUT_TDATA_W-1:0]   out_tdata_o,
  output logic [sws_pkg::KIND_W-1:0]        out_tuser_o,
  output logic                              out_tlast_o
);

  localparam int unsigned IW   = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW   = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned WW   = (CW > sws_pkg::WIN_W) ? CW : sws_pkg::WIN_W;
  localparam int unsigned CMPW = (TIME_BITS > sws_pkg::CFG_W) ? TIME_BITS : sws_pkg::CFG_W;

  function automatic logic [IW-1:0] wrap_add(logic [IW-1:0] a, logic [CW-1:0] b);
    logic [IW:0] s;
    s = (IW+1)'(a) + (IW+1)'(b);
    if (s >= (IW+1)'(BUFFER_DEPTH)) s = s - (IW+1)'(BUFFER_DEPTH);
    return s[IW-1:0];
  endfunction

  logic [sws_pkg::FUNC_W-1:0] func_q;
  logic [sws_pkg::LEN_W-1:0]  plen_q;
  logic [sws_pkg::SEQ_W-1:0]  aseq_q;
  logic [sws_pkg::WIN_W-1:0]  awin_q;
  logic [TIME_BITS-1:0]       now_q;

  logic [IW-1:0]              head_q;
  logic [CW-1:0]              count_q;
  logic [sws_pkg::WIN_W-1:0]  win_q;
  logic [sws_pkg::SEQ_W-1:0]  nseq_q;
  logic                       eofs_q, eofa_q;
  logic [sws_pkg::CFG_W-1:0]  timeout_q;
  logic [BUFFER_DEPTH-1:0]    sent_q;
  logic [CW-1:0]              idx_q;
  logic [BUFFER_DEPTH-1:0]    due_q;
  logic                       any_due_q;
  logic [IW-1:0]              last_due_q;
  logic                       eof_pend_q;
  logic [CW-1:0]              removed_q;

  logic [sws_pkg::SEQ_W-1:0]  mem_seq  [BUFFER_DEPTH];
  logic [sws_pkg::LEN_W-1:0]  mem_len  [BUFFER_DEPTH];
  logic [TIME_BITS-1:0]       mem_time [BUFFER_DEPTH];
  logic [sws_pkg::SEQ_W-1:0]  rd_seq_q;
  logic [sws_pkg::LEN_W-1:0]  rd_len_q;
  logic [TIME_BITS-1:0]       rd_time_q;

  logic                       out_valid_q;
  sws_pkg::kind_e             kind_q, kind_d;
  logic [sws_pkg::SEQ_W-1:0]  oseq_q, oseq_d;
  logic [sws_pkg::SLOT_W-1:0] oslot_q, oslot_d;
  logic [sws_pkg::LEN_W-1:0]  olen_q, olen_d;
  logic                       olast_q, olast_d;
  logic [sws_pkg::OCC_W-1:0]  oocc_q, oocc_d;
  logic [sws_pkg::OCC_W-1:0]  orem_q, orem_d;
  logic                       oeofs_q, oeofs_d;
  logic                       oeofa_q, oeofa_d;

  logic [IW-1:0]              idx_lo;
  logic [IW-1:0]              walk_slot;
  logic [IW-1:0]              tail_slot;
  logic [IW-1:0]              head_next;
  logic                       enq_ok;
  logic [TIME_BITS-1:0]       age;
  logic                       due_now;
  logic                       out_load;

  assign idx_lo    = idx_q[IW-1:0];
  assign walk_slot = wrap_add(head_q, idx_q);
  assign tail_slot = wrap_add(head_q, count_q);
  assign head_next = wrap_add(head_q, CW'(1));
  assign enq_ok    = (plen_q <= sws_pkg::LEN_W'(sws_pkg::MAX_PAYLOAD)) &&
                     (count_q < CW'(BUFFER_DEPTH));
  assign age       = now_q - rd_time_q;
  assign due_now   = !sent_q[walk_slot] || (CMPW'(age) >= CMPW'(timeout_q));
  assign out_load  = cmd_i.enq | cmd_i.send_eval | cmd_i.poll_none | cmd_i.ack_emit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= in_tuser_i;
      plen_q <= in_tdata_i[sws_pkg::IN_LEN_LSB +: sws_pkg::LEN_W];
      aseq_q <= in_tdata_i[sws_pkg::IN_ASEQ_LSB +: sws_pkg::SEQ_W];
      awin_q <= in_tdata_i[sws_pkg::IN_AWIN_LSB +: sws_pkg::WIN_W];
      now_q  <= TIME_BITS'(in_tdata_i[sws_pkg::IN_NOW_LSB +: sws_pkg::NOW_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq && enq_ok) begin
      mem_seq[tail_slot] <= nseq_q;
      mem_len[tail_slot] <= plen_q;
    end
    if (cmd_i.send_eval) begin
      mem_time[walk_slot] <= now_q;
    end
    if (cmd_i.rd) begin
      rd_seq_q  <= mem_seq[walk_slot];
      rd_len_q  <= mem_len[walk_slot];
      rd_time_q <= mem_time[walk_slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      win_q      <= sws_pkg::WIN_W'(sws_pkg::WINDOW_RST);
      nseq_q     <= '0;
      eofs_q     <= 1'b0;
      eofa_q     <= 1'b0;
      timeout_q  <= sws_pkg::CFG_W'(sws_pkg::TIMEOUT_RST);
      sent_q     <= '0;
      idx_q      <= '0;
      due_q      <= '0;
      any_due_q  <= 1'b0;
      last_due_q <= '0;
      eof_pend_q <= 1'b0;
      removed_q  <= '0;
    end else begin
      if (cfg_we_i) timeout_q <= cfg_wdata_i;
      if (cmd_i.enq && enq_ok) begin
        sent_q[tail_slot] <= 1'b0;
        count_q           <= count_q + CW'(1);
        nseq_q            <= nseq_q + sws_pkg::SEQ_W'(1);
      end
      if (cmd_i.scan_init) begin
        idx_q      <= '0;
        due_q      <= '0;
        any_due_q  <= 1'b0;
        last_due_q <= '0;
        eof_pend_q <= 1'b0;
      end
      if (cmd_i.send_init) idx_q <= '0;
      if (cmd_i.scan_eval) begin
        idx_q <= idx_q + CW'(1);
        if (due_now) begin
          due_q[idx_lo] <= 1'b1;
          any_due_q     <= 1'b1;
          last_due_q    <= idx_lo;
          if (rd_len_q == '0) eof_pend_q <= 1'b1;
        end
      end
      if (cmd_i.idx_inc) idx_q <= idx_q + CW'(1);
      if (cmd_i.send_eval) begin
        sent_q[walk_slot] <= 1'b1;
        idx_q             <= idx_q + CW'(1);
        eofs_q            <= eofs_q | eof_pend_q;
      end
      if (cmd_i.ack_start) begin
        win_q     <= awin_q;
        removed_q <= '0;
        idx_q     <= '0;
      end
      if (cmd_i.ack_pop) begin
        sent_q[head_q] <= 1'b0;
        if (rd_len_q == '0) eofa_q <= 1'b1;
        head_q    <= head_next;
        count_q   <= count_q - CW'(1);
        removed_q <= removed_q + CW'(1);
      end
    end
  end

  always_comb begin
    kind_d  = sws_pkg::KIND_POLL_NONE;
    oseq_d  = '0;
    oslot_d = '0;
    olen_d  = '0;
    olast_d = 1'b1;
    oocc_d  = sws_pkg::OCC_W'(count_q);
    orem_d  = '0;
    oeofs_d = eofs_q;
    oeofa_d = eofa_q;
    priority if (cmd_i.enq) begin
      olen_d = plen_q;
      if (enq_ok) begin
        kind_d  = sws_pkg::KIND_ACCEPTED;
        oseq_d  = nseq_q;
        oslot_d = sws_pkg::SLOT_W'(tail_slot);
        oocc_d  = sws_pkg::OCC_W'(count_q + CW'(1));
      end else begin
        kind_d  = sws_pkg::KIND_REJECTED;
      end
    end else if (cmd_i.send_eval) begin
      kind_d  = sws_pkg::KIND_SEND;
      oseq_d  = rd_seq_q;
      oslot_d = sws_pkg::SLOT_W'(walk_slot);
      olen_d  = rd_len_q;
      olast_d = (idx_lo == last_due_q);
      oeofs_d = eofs_q | eof_pend_q;
    end else if (cmd_i.ack_emit) begin
      kind_d  = sws_pkg::KIND_ACK_DONE;
      oseq_d  = aseq_q;
      oslot_d = sws_pkg::SLOT_W'(head_q);
      orem_d  = sws_pkg::OCC_W'(removed_q);
    end else begin
      kind_d  = sws_pkg::KIND_POLL_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q  <= kind_d;
      oseq_q  <= oseq_d;
      oslot_q <= oslot_d;
      olen_q  <= olen_d;
      olast_q <= olast_d;
      oocc_q  <= oocc_d;
      orem_q  <= orem_d;
      oeofs_q <= oeofs_d;
      oeofa_q <= oeofa_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tuser_o = kind_q;
  assign out_tlast_o = olast_q;
  assign out_tdata_o = {3'b000, oeofa_q, oeofs_q, orem_q, oocc_q, olen_q, oslot_q, oseq_q};

  always_comb begin
    status_o.func       = sws_pkg::func_e'(func_q);
    status_o.walk_more  = (WW'(idx_q) < WW'(win_q)) && (idx_q < count_q);
    status_o.due_cur    = due_q[idx_lo];
    status_o.any_due    = any_due_q;
    status_o.ring_empty = (count_q == '0);
    status_o.ack_hit    = (rd_seq_q == aseq_q);
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

### rtl/sliding_window_sender.sv
// Sliding-window sender: keeps a ring of pending packet descriptors, numbers
// enqueued packets, requests sends and resends inside the receiver window and
// releases entries on cumulative acknowledgment. One item is taken at a time.
// An enqueue is decoded and then waits for the result port. An acknowledgment
// reads and checks entries from the head, releasing each one until the
// acknowledged number is found or the release empties the ring. A send poll
// first scans the entries inside min(window, occupancy) for due ones; when any
// entry is due it then walks them again, issuing a send request per due entry.
// Each entry visited is read from the single-port descriptor memory with
// registered read before it is evaluated; any wait on the result port stalls.
// Results carry the flags and occupancy as they stand after the whole item.
// Depends on sws_pkg, sws_ctrl and sws_datapath.
module sliding_window_sender #(
  parameter int unsigned BUFFER_DEPTH = sws_pkg::BUFFER_DEPTH_DEF,
  parameter int unsigned TIME_BITS    = sws_pkg::TIME_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sws_pkg::CFG_W-1:0]        cfg_wdata_i,     // retransmit_timeout
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // payload_length[9:0], ack_seqnum[17:10], ack_window[22:18], now[54:23], zero[55]
  input  logic [sws_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  input  logic [sws_pkg::FUNC_W-1:0]       s_axis_tuser_i,  // func[1:0]
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // seqnum[7:0], slot[12:8], out_length[22:13], occupancy[28:23], removed[34:29],
  // eof_sent_out[35], eof_acked_out[36], zero[39:37]
  output logic [sws_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic [sws_pkg::KIND_W-1:0]       m_axis_tuser_o,  // kind[2:0]
  output logic                             m_axis_tlast_o
);

  sws_pkg::cmd_t    cmd;
  sws_pkg::status_t status;

  sws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sws_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .TIME_BITS    (TIME_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_tdata_i  (s_axis_tdata_i),
    .in_tuser_i  (s_axis_tuser_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_tdata_o (m_axis_tdata_o),
    .out_tuser_o (m_axis_tuser_o),
    .out_tlast_o (m_axis_tlast_o)
  );

  a_single_results_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == sws_pkg::KIND_POLL_NONE ||
                         m_axis_tuser_o == sws_pkg::KIND_ACK_DONE ||
                         m_axis_tuser_o == sws_pkg::KIND_ACCEPTED ||
                         m_axis_tuser_o == sws_pkg::KIND_REJECTED)) |-> m_axis_tlast_o)
    else $error("single-result item delivered without last");

  a_idle_no_open_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !(m_axis_tvalid_o && !m_axis_tlast_o))
    else $error("input taken while a poll still has results to issue");

  a_no_poll_without_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready_o && !s_axis_tvalid_i) |=> !cmd.enq && !cmd.scan_init && !cmd.ack_start)
    else $error("item processing started without an input transfer");

endmodule
